// ===== rtl/morse_character_keyer_macros.svh =====
// ---------------------------------------------------------------------------
// Morse keyer assertion macros
// Shared concurrent assertion forms, clocked on clk and held off during
// reset.
// ---------------------------------------------------------------------------
`ifndef MORSE_CHARACTER_KEYER_MACROS_SVH
`define MORSE_CHARACTER_KEYER_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define MCK_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("mck: same-cycle check failed");

// Consequent must hold in the cycle after the antecedent.
`define MCK_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("mck: next-cycle check failed");

`endif

// ===== rtl/mck_pkg.sv =====
// ---------------------------------------------------------------------------
// Morse keyer package
// Field widths, register indexes, character codes, segment operations and
// the International Morse code table.
// ---------------------------------------------------------------------------
package mck_pkg;

  localparam int CHAR_W  = 8;
  localparam int TIME_W  = 16;
  localparam int DUR_W   = 19;
  localparam int INDEX_W = 2;

  // Register indexes of the configuration port
  localparam logic [INDEX_W-1:0] REG_DOT  = 2'd0;
  localparam logic [INDEX_W-1:0] REG_DASH = 2'd1;
  localparam logic [INDEX_W-1:0] REG_GAP  = 2'd2;

  localparam logic [TIME_W-1:0] DOT_RESET  = 16'd250;
  localparam logic [TIME_W-1:0] DASH_RESET = 16'd750;
  localparam logic [TIME_W-1:0] GAP_RESET  = 16'd250;

  localparam logic [CHAR_W-1:0] CH_SPACE   = 8'h20;
  localparam logic [CHAR_W-1:0] CH_ZERO    = 8'h30;
  localparam logic [CHAR_W-1:0] CH_NINE    = 8'h39;
  localparam logic [CHAR_W-1:0] CH_UPPER_A = 8'h41;
  localparam logic [CHAR_W-1:0] CH_UPPER_Z = 8'h5A;
  localparam logic [CHAR_W-1:0] CH_LOWER_A = 8'h61;
  localparam logic [CHAR_W-1:0] CH_LOWER_Z = 8'h7A;
  localparam logic [CHAR_W-1:0] CASE_FOLD  = 8'd32;

  localparam logic [5:0] DIGIT_BASE = 6'd26;

  // Duration operations of the shared scaler
  typedef enum logic [2:0] {
    OP_DOT,
    OP_DASH,
    OP_GAP2,
    OP_GAP3,
    OP_GAP4,
    OP_GAP7
  } op_t;

  // Element count and pattern; pattern bit i set means element i is a dash
  typedef struct packed {
    logic [2:0] len;
    logic [4:0] pat;
  } code_t;

  function automatic code_t code_lookup(input logic [5:0] idx);
    code_t c;
    unique case (idx)
      6'd0:  c = '{len: 3'd2, pat: 5'b00010}; // A
      6'd1:  c = '{len: 3'd4, pat: 5'b00001}; // B
      6'd2:  c = '{len: 3'd4, pat: 5'b00101}; // C
      6'd3:  c = '{len: 3'd3, pat: 5'b00001}; // D
      6'd4:  c = '{len: 3'd1, pat: 5'b00000}; // E
      6'd5:  c = '{len: 3'd4, pat: 5'b00100}; // F
      6'd6:  c = '{len: 3'd3, pat: 5'b00011}; // G
      6'd7:  c = '{len: 3'd4, pat: 5'b00000}; // H
      6'd8:  c = '{len: 3'd2, pat: 5'b00000}; // I
      6'd9:  c = '{len: 3'd4, pat: 5'b01110}; // J
      6'd10: c = '{len: 3'd3, pat: 5'b00101}; // K
      6'd11: c = '{len: 3'd4, pat: 5'b00010}; // L
      6'd12: c = '{len: 3'd2, pat: 5'b00011}; // M
      6'd13: c = '{len: 3'd2, pat: 5'b00001}; // N
      6'd14: c = '{len: 3'd3, pat: 5'b00111}; // O
      6'd15: c = '{len: 3'd4, pat: 5'b00110}; // P
      6'd16: c = '{len: 3'd4, pat: 5'b01011}; // Q
      6'd17: c = '{len: 3'd3, pat: 5'b00010}; // R
      6'd18: c = '{len: 3'd3, pat: 5'b00000}; // S
      6'd19: c = '{len: 3'd1, pat: 5'b00001}; // T
      6'd20: c = '{len: 3'd3, pat: 5'b00100}; // U
      6'd21: c = '{len: 3'd4, pat: 5'b01000}; // V
      6'd22: c = '{len: 3'd3, pat: 5'b00110}; // W
      6'd23: c = '{len: 3'd4, pat: 5'b01001}; // X
      6'd24: c = '{len: 3'd4, pat: 5'b01101}; // Y
      6'd25: c = '{len: 3'd4, pat: 5'b00011}; // Z
      6'd26: c = '{len: 3'd5, pat: 5'b11111}; // 0
      6'd27: c = '{len: 3'd5, pat: 5'b11110}; // 1
      6'd28: c = '{len: 3'd5, pat: 5'b11100}; // 2
      6'd29: c = '{len: 3'd5, pat: 5'b11000}; // 3
      6'd30: c = '{len: 3'd5, pat: 5'b10000}; // 4
      6'd31: c = '{len: 3'd5, pat: 5'b00000}; // 5
      6'd32: c = '{len: 3'd5, pat: 5'b00001}; // 6
      6'd33: c = '{len: 3'd5, pat: 5'b00011}; // 7
      6'd34: c = '{len: 3'd5, pat: 5'b00111}; // 8
      6'd35: c = '{len: 3'd5, pat: 5'b01111}; // 9
      default: c = '{len: 3'd1, pat: 5'b00000};
    endcase
    return c;
  endfunction

endpackage

// ===== rtl/mck_in_if.sv =====
// ---------------------------------------------------------------------------
// Morse keyer character channel
// Valid/ready channel carrying one ASCII character per request.
// ---------------------------------------------------------------------------
interface mck_in_if;
  logic                         valid;
  logic                         ready;
  logic [mck_pkg::CHAR_W-1:0]   character;

  modport source (output valid, output character, input ready);
  modport sink   (input valid, input character, output ready);
endinterface

// ===== rtl/mck_out_if.sv =====
// ---------------------------------------------------------------------------
// Morse keyer segment channel
// Valid/ready channel carrying one timed signal segment per request.
// ---------------------------------------------------------------------------
interface mck_out_if;
  logic                        valid;
  logic                        ready;
  logic                        level;
  logic [mck_pkg::DUR_W-1:0]   duration;
  logic                        last;

  modport source (output valid, output level, output duration, output last, input ready);
  modport sink   (input valid, input level, input duration, input last, output ready);
endinterface

// ===== rtl/mck_cfg_if.sv =====
// ---------------------------------------------------------------------------
// Morse keyer configuration channel
// Valid/ready write channel carrying a register index and write data.
// ---------------------------------------------------------------------------
interface mck_cfg_if;
  logic                          valid;
  logic                          ready;
  logic [mck_pkg::INDEX_W-1:0]   index;
  logic [mck_pkg::TIME_W-1:0]    data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== rtl/mck_alu.sv =====
// ---------------------------------------------------------------------------
// Morse keyer duration scaler
// One shift-add-subtract unit that forms every segment duration: dot or dash
// time as is, or the gap unit times 2, 3, 4 or 7.
// ---------------------------------------------------------------------------
module mck_alu (
  input  mck_pkg::op_t                 op,
  input  logic [mck_pkg::TIME_W-1:0]   dot_time,
  input  logic [mck_pkg::TIME_W-1:0]   dash_time,
  input  logic [mck_pkg::TIME_W-1:0]   gap_time,
  output logic [mck_pkg::DUR_W-1:0]    duration
);

  typedef enum logic [1:0] {
    MODE_PASS,
    MODE_ADD,
    MODE_SUB
  } mode_t;

  logic [mck_pkg::TIME_W-1:0] base;
  logic [1:0]                 shamt;
  mode_t                      mode;
  logic [mck_pkg::DUR_W-1:0]  base_ext;
  logic [mck_pkg::DUR_W-1:0]  shifted;

  always_comb begin
    unique case (op)
      mck_pkg::OP_DOT:  begin base = dot_time;  shamt = 2'd0; mode = MODE_PASS; end
      mck_pkg::OP_DASH: begin base = dash_time; shamt = 2'd0; mode = MODE_PASS; end
      mck_pkg::OP_GAP2: begin base = gap_time;  shamt = 2'd1; mode = MODE_PASS; end
      mck_pkg::OP_GAP3: begin base = gap_time;  shamt = 2'd1; mode = MODE_ADD;  end
      mck_pkg::OP_GAP4: begin base = gap_time;  shamt = 2'd2; mode = MODE_PASS; end
      mck_pkg::OP_GAP7: begin base = gap_time;  shamt = 2'd3; mode = MODE_SUB;  end
      default:          begin base = gap_time;  shamt = 2'd0; mode = MODE_PASS; end
    endcase
  end

  assign base_ext = {{(mck_pkg::DUR_W-mck_pkg::TIME_W){1'b0}}, base};
  assign shifted  = base_ext << shamt;

  always_comb begin
    case (mode)
      MODE_ADD: duration = shifted + base_ext;
      MODE_SUB: duration = shifted - base_ext;
      default:  duration = shifted;
    endcase
  end

endmodule

// ===== rtl/mck_seq.sv =====
// ---------------------------------------------------------------------------
// Morse keyer sequencer
// Classifies an accepted character, then steps through its segments one
// per cycle while the output is not stalled, driving the scaler and
// holding each segment in the output register until it is taken.
// ---------------------------------------------------------------------------
module mck_seq (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  input  logic [mck_pkg::CHAR_W-1:0]    in_character,
  output logic                          in_ready,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic                          out_level,
  output logic [mck_pkg::DUR_W-1:0]     out_duration,
  output logic                          out_last,
  output mck_pkg::op_t                  op,
  input  logic [mck_pkg::DUR_W-1:0]     seg_duration
);

  typedef enum logic {
    S_IDLE,
    S_SEND
  } state_t;

  typedef enum logic [1:0] {
    K_SPACE,
    K_OTHER,
    K_CODE
  } kind_t;

  state_t                       state_r, state_nxt;
  kind_t                        kind_r, kind_nxt;
  logic [4:0]                   pat_r, pat_nxt;
  logic [2:0]                   len_r, len_nxt;
  logic [2:0]                   cnt_r, cnt_nxt;
  logic                         phase_r, phase_nxt;
  logic                         out_valid_r, out_valid_nxt;
  logic                         out_level_r, out_level_nxt;
  logic [mck_pkg::DUR_W-1:0]    out_duration_r, out_duration_nxt;
  logic                         out_last_r, out_last_nxt;

  logic [mck_pkg::CHAR_W-1:0]   ch_up;
  logic [mck_pkg::CHAR_W-1:0]   ch_off;
  logic [5:0]                   idx;
  mck_pkg::code_t               code;
  kind_t                        kind_in;
  logic                         accept;
  logic                         load;
  logic                         final_elem;
  logic                         seg_level;
  logic                         seg_last;

  // Fold case and classify the incoming character
  always_comb begin
    ch_up  = in_character;
    ch_off = '0;
    idx    = '0;
    if (in_character >= mck_pkg::CH_LOWER_A && in_character <= mck_pkg::CH_LOWER_Z) begin
      ch_up = in_character - mck_pkg::CASE_FOLD;
    end
    if (ch_up == mck_pkg::CH_SPACE) begin
      kind_in = K_SPACE;
    end else if (ch_up >= mck_pkg::CH_UPPER_A && ch_up <= mck_pkg::CH_UPPER_Z) begin
      kind_in = K_CODE;
      ch_off  = ch_up - mck_pkg::CH_UPPER_A;
      idx     = ch_off[5:0];
    end else if (ch_up >= mck_pkg::CH_ZERO && ch_up <= mck_pkg::CH_NINE) begin
      kind_in = K_CODE;
      ch_off  = ch_up - mck_pkg::CH_ZERO;
      idx     = mck_pkg::DIGIT_BASE + ch_off[5:0];
    end else begin
      kind_in = K_OTHER;
    end
  end

  assign code = mck_pkg::code_lookup(idx);

  // Segment under way
  assign final_elem = (cnt_r == len_r - 3'd1);
  assign seg_level  = (kind_r == K_CODE) && !phase_r;
  assign seg_last   = (kind_r != K_CODE) || (phase_r && final_elem);

  always_comb begin
    unique case (kind_r)
      K_SPACE: op = mck_pkg::OP_GAP7;
      K_OTHER: op = mck_pkg::OP_GAP3;
      K_CODE: begin
        if (!phase_r) begin
          op = pat_r[cnt_r] ? mck_pkg::OP_DASH : mck_pkg::OP_DOT;
        end else begin
          op = final_elem ? mck_pkg::OP_GAP4 : mck_pkg::OP_GAP2;
        end
      end
      default: op = mck_pkg::OP_GAP3;
    endcase
  end

  assign accept = (state_r == S_IDLE) && in_valid;
  assign load   = (state_r == S_SEND) && (!out_valid_r || out_ready);

  always_comb begin
    state_nxt        = state_r;
    kind_nxt         = kind_r;
    pat_nxt          = pat_r;
    len_nxt          = len_r;
    cnt_nxt          = cnt_r;
    phase_nxt        = phase_r;
    out_level_nxt    = out_level_r;
    out_duration_nxt = out_duration_r;
    out_last_nxt     = out_last_r;
    out_valid_nxt    = out_ready ? 1'b0 : out_valid_r;
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          state_nxt = S_SEND;
          kind_nxt  = kind_in;
          pat_nxt   = code.pat;
          len_nxt   = code.len;
          cnt_nxt   = '0;
          phase_nxt = 1'b0;
        end
      end
      S_SEND: begin
        if (load) begin
          out_valid_nxt    = 1'b1;
          out_level_nxt    = seg_level;
          out_duration_nxt = seg_duration;
          out_last_nxt     = seg_last;
          if (seg_last) begin
            state_nxt = S_IDLE;
          end else if (phase_r) begin
            cnt_nxt   = cnt_r + 3'd1;
            phase_nxt = 1'b0;
          end else begin
            phase_nxt = 1'b1;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r        <= state_nxt;
      out_valid_r    <= out_valid_nxt;
      kind_r         <= kind_nxt;
      pat_r          <= pat_nxt;
      len_r          <= len_nxt;
      cnt_r          <= cnt_nxt;
      phase_r        <= phase_nxt;
      out_level_r    <= out_level_nxt;
      out_duration_r <= out_duration_nxt;
      out_last_r     <= out_last_nxt;
    end
  end

  assign in_ready     = (state_r == S_IDLE);
  assign out_valid    = out_valid_r;
  assign out_level    = out_level_r;
  assign out_duration = out_duration_r;
  assign out_last     = out_last_r;

endmodule

// ===== rtl/morse_character_keyer.sv =====
// ---------------------------------------------------------------------------
// Morse character keyer
// Turns one ASCII character into the timed on/off segments of its
// International Morse code.
// ---------------------------------------------------------------------------
// Each accepted character request yields one to ten segment requests on the
// output channel. Lower case is folded to upper case. A letter or digit
// gives, for each element, an on segment of dot_time or dash_time followed
// by an off segment of 2 * gap_time, or 4 * gap_time after the final
// element; a space gives one off segment of 7 * gap_time and any other byte
// one off segment of 3 * gap_time. The final segment of a character carries
// last = 1. The block accepts and classifies a character, then loads its
// segments into the output register one per cycle while the output is
// ready; the sequencer steps through a single shift-add-subtract scaler,
// and input ready stays low until the last segment has been loaded into
// the output register. Registers dot_time (index 0), dash_time (index 1)
// and gap_time (index 2) reset to 250, 750 and 250 ms; writes to other
// indexes are dropped. Write them only while idle.
// ---------------------------------------------------------------------------
`include "morse_character_keyer_macros.svh"

module morse_character_keyer (
  input  logic          clk,
  input  logic          rst_n,
  mck_in_if.sink        in_ch,
  mck_out_if.source     out_ch,
  mck_cfg_if.sink       cfg_ch
);

  // Timing registers
  logic [mck_pkg::TIME_W-1:0] dot_time_r;
  logic [mck_pkg::TIME_W-1:0] dash_time_r;
  logic [mck_pkg::TIME_W-1:0] gap_time_r;

  // Scaler hookup
  mck_pkg::op_t               op;
  logic [mck_pkg::DUR_W-1:0]  seg_duration;

  // Configuration writes are always taken
  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dot_time_r  <= mck_pkg::DOT_RESET;
      dash_time_r <= mck_pkg::DASH_RESET;
      gap_time_r  <= mck_pkg::GAP_RESET;
    end else if (cfg_ch.valid) begin
      unique case (cfg_ch.index)
        mck_pkg::REG_DOT:  dot_time_r  <= cfg_ch.data;
        mck_pkg::REG_DASH: dash_time_r <= cfg_ch.data;
        mck_pkg::REG_GAP:  gap_time_r  <= cfg_ch.data;
        default: ; // drop writes to unknown indexes
      endcase
    end
  end

  // Shared duration scaler
  mck_alu u_alu (
    .op        (op),
    .dot_time  (dot_time_r),
    .dash_time (dash_time_r),
    .gap_time  (gap_time_r),
    .duration  (seg_duration)
  );

  // Segment sequencer with output register
  mck_seq u_seq (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_ch.valid),
    .in_character (in_ch.character),
    .in_ready     (in_ch.ready),
    .out_valid    (out_ch.valid),
    .out_ready    (out_ch.ready),
    .out_level    (out_ch.level),
    .out_duration (out_ch.duration),
    .out_last     (out_ch.last),
    .op           (op),
    .seg_duration (seg_duration)
  );

  // An accepted character always holds the input off in the cycle after it is taken
  `MCK_ASSERT_NEXT(a_busy_after_accept, in_ch.valid && in_ch.ready, !in_ch.ready)
  // An on segment is never the final segment of a character
  `MCK_ASSERT_SAME(a_on_not_last, out_ch.valid && out_ch.level, !out_ch.last)
  // Input stays closed while a non-final segment is waiting on the output
  `MCK_ASSERT_SAME(a_closed_mid_char, out_ch.valid && !out_ch.last, !in_ch.ready)

endmodule
